>>> src/dfvo_pkg.sv
// Package for the diagonal frequency value order block.
// Holds sizes, register indexes, the job descriptor type and ordering codes.
// No dependencies.
`default_nettype none
package dfvo_pkg;

  // Largest grid order handled
  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  // Field widths fixed by the interface
  localparam int VAL_W     = 5;
  localparam int CNT_W     = 3;
  localparam int NB_NUM    = 4;
  localparam int MASK_W    = 17;
  localparam int CFG_W     = 5;
  // Job queue depth between front and back
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);

  // Ordering codes
  localparam logic MODE_ASCENDING    = 1'b0;
  localparam logic MODE_BY_FREQUENCY = 1'b1;

  // Configuration register indexes
  localparam logic CFG_ORDERING_MODE = 1'b0;
  localparam logic CFG_ORDER_SIZE    = 1'b1;

  // One classified item: mode, allowed candidates (bit i = value i+1), counts
  typedef struct packed {
    logic                            mode;
    logic [MAX_ORDER-1:0]            allowed;
    logic [MAX_ORDER-1:0][CNT_W-1:0] cnt;
  } job_t;

endpackage
`default_nettype wire

>>> src/dfvo_front.sv
// Front end: classifies an accepted item into a job descriptor.
// Builds the candidate set and per-value neighbor counts. Uses dfvo_pkg.
`default_nettype none
module dfvo_front (
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [39:0]               in_tdata,
  input  wire logic [0:0]                in_tuser,
  input  wire logic                      ordering_mode,
  input  wire logic [dfvo_pkg::CFG_W-1:0] order_size,
  input  wire logic                      q_full,
  output logic                           push,
  output dfvo_pkg::job_t                 job
);

  logic [dfvo_pkg::VAL_W-1:0]  nb [dfvo_pkg::NB_NUM];
  logic [dfvo_pkg::MASK_W-1:0] mask;
  logic                        use_mask;
  logic [dfvo_pkg::CFG_W-1:0]  size_eff;

  // Unpack fields
  assign nb[0]    = in_tdata[4:0];
  assign nb[1]    = in_tdata[9:5];
  assign nb[2]    = in_tdata[14:10];
  assign nb[3]    = in_tdata[19:15];
  assign mask     = in_tdata[36:20];
  assign use_mask = in_tuser[0];

  // Sizes above the maximum saturate
  assign size_eff = (order_size > dfvo_pkg::CFG_W'(dfvo_pkg::MAX_ORDER)) ?
                    dfvo_pkg::CFG_W'(dfvo_pkg::MAX_ORDER) : order_size;

  // Candidate set and counts, one lane per value
  always_comb begin
    job.mode = ordering_mode;
    for (int i = 0; i < dfvo_pkg::MAX_ORDER; i++) begin
      job.allowed[i] = (dfvo_pkg::CFG_W'(i + 1) <= size_eff) &&
                       (!use_mask || mask[i + 1]);
      job.cnt[i] = '0;
      for (int k = 0; k < dfvo_pkg::NB_NUM; k++) begin
        if (nb[k] == dfvo_pkg::VAL_W'(i + 1)) begin
          job.cnt[i] = job.cnt[i] + dfvo_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Items with no candidates produce nothing and are dropped here
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full && (|job.allowed);

endmodule
`default_nettype wire

>>> src/dfvo_queue.sv
// Short job queue between front end and back end.
// Register array with head and tail pointers. Uses dfvo_pkg.
`default_nettype none
module dfvo_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  dfvo_pkg::job_t      push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                q_valid,
  output dfvo_pkg::job_t      head_job
);

  localparam int CNT_QW = $clog2(dfvo_pkg::Q_DEPTH + 1);

  dfvo_pkg::job_t                 mem_r [dfvo_pkg::Q_DEPTH];
  logic [dfvo_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [dfvo_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0]              fill_r, fill_nxt;
  logic                           do_pop;

  assign full     = (fill_r == CNT_QW'(dfvo_pkg::Q_DEPTH));
  assign q_valid  = (fill_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  // Pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == dfvo_pkg::QPTR_W'(dfvo_pkg::Q_DEPTH - 1)) ?
                   '0 : wr_ptr_r + dfvo_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dfvo_pkg::QPTR_W'(dfvo_pkg::Q_DEPTH - 1)) ?
                   '0 : rd_ptr_r + dfvo_pkg::QPTR_W'(1);
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + CNT_QW'(1);
    end else if (do_pop && !push) begin
      fill_nxt = fill_r - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

>>> src/dfvo_back.sv
// Back end: walks one job and emits its candidates one per cycle unless the
// output stalls. Picks the next value from the remaining set, output register
// on the result side. Uses dfvo_pkg.
`default_nettype none
module dfvo_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  dfvo_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  logic                                      busy_r, busy_nxt;
  logic                                      mode_r;
  logic [dfvo_pkg::MAX_ORDER-1:0]            rem_r, rem_nxt;
  logic [dfvo_pkg::MAX_ORDER-1:0][dfvo_pkg::CNT_W-1:0] cnt_r;
  logic                                      ov_r, ov_nxt;
  logic [dfvo_pkg::VAL_W-1:0]                val_r;
  logic [dfvo_pkg::CNT_W-1:0]                oc_r;
  logic                                      last_r;

  logic                                      adv, step;
  logic [dfvo_pkg::CNT_W-1:0]                cls;
  logic                                      found;
  logic [dfvo_pkg::MAX_ORDER-1:0]            vec_sel;
  logic [dfvo_pkg::IDX_W-1:0]                idx;
  logic [dfvo_pkg::MAX_ORDER-1:0]            rem_left;

  assign adv  = !ov_r || out_tready;
  assign step = busy_r && adv;
  assign pop  = !busy_r && q_valid;

  // Highest nonempty count class among remaining candidates
  always_comb begin
    cls   = '0;
    found = 1'b0;
    for (int c = dfvo_pkg::NB_NUM; c >= 0; c--) begin
      if (!found) begin
        for (int i = 0; i < dfvo_pkg::MAX_ORDER; i++) begin
          if (rem_r[i] && cnt_r[i] == dfvo_pkg::CNT_W'(c)) begin
            found = 1'b1;
          end
        end
        if (found) begin
          cls = dfvo_pkg::CNT_W'(c);
        end
      end
    end
  end

  // Priority pick: lowest value in sequential mode, highest in its class else
  always_comb begin
    idx = '0;
    for (int i = 0; i < dfvo_pkg::MAX_ORDER; i++) begin
      vec_sel[i] = rem_r[i] && (cnt_r[i] == cls);
    end
    if (mode_r == dfvo_pkg::MODE_BY_FREQUENCY) begin
      for (int i = 0; i < dfvo_pkg::MAX_ORDER; i++) begin
        if (vec_sel[i]) idx = dfvo_pkg::IDX_W'(i);
      end
    end else begin
      for (int i = dfvo_pkg::MAX_ORDER - 1; i >= 0; i--) begin
        if (rem_r[i]) idx = dfvo_pkg::IDX_W'(i);
      end
    end
    rem_left      = rem_r;
    rem_left[idx] = 1'b0;
  end

  // Control next state
  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    ov_nxt   = ov_r;
    if (pop) begin
      busy_nxt = 1'b1;
      rem_nxt  = head_job.allowed;
    end else if (step) begin
      rem_nxt  = rem_left;
      busy_nxt = (rem_left != '0);
    end
    if (step) begin
      ov_nxt = 1'b1;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
      ov_r   <= ov_nxt;
    end
  end

  // Job payload and result registers
  always_ff @(posedge clk) begin
    if (pop) begin
      mode_r <= head_job.mode;
      cnt_r  <= head_job.cnt;
    end
    if (step) begin
      val_r  <= dfvo_pkg::VAL_W'(idx) + dfvo_pkg::VAL_W'(1);
      oc_r   <= (mode_r == dfvo_pkg::MODE_BY_FREQUENCY) ? cls : '0;
      last_r <= (rem_left == '0);
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {oc_r, val_r};
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

>>> src/diagonal_frequency_value_order.sv
// Diagonal frequency value order, top level. An item's first result passes the job
// queue, the back-end load and the output register. Throughput: one result per
// cycle unless the output stalls; the back end loads an item, then picks its n
// candidates in turn; a two-entry job queue lets the front accept meanwhile.
// Reset: synchronous active-low rst_n clears queue, control and config.
// Depends on dfvo_pkg, dfvo_front, dfvo_queue, dfvo_back.
`default_nettype none
module diagonal_frequency_value_order (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // in_tdata: neighbour_down_right[4:0], neighbour_down_left[9:5],
  //           neighbour_up_right[14:10], neighbour_up_left[19:15],
  //           candidate_mask[36:20], zero pad[39:37]
  input  wire logic [39:0]                 in_tdata,
  // in_tuser: use_mask[0]
  input  wire logic [0:0]                  in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // out_tdata: value[4:0], neighbour_count[7:5]
  output logic [7:0]                       out_tdata,
  output logic                             out_tlast,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [dfvo_pkg::CFG_W-1:0]  cfg_wdata
);

  logic                        mode_r;
  logic [dfvo_pkg::CFG_W-1:0]  size_r;
  logic                        push, q_full, q_valid, pop;
  dfvo_pkg::job_t              push_job, head_job;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dfvo_pkg::MODE_ASCENDING;
      size_r <= dfvo_pkg::CFG_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        dfvo_pkg::CFG_ORDERING_MODE: mode_r <= cfg_wdata[0];
        dfvo_pkg::CFG_ORDER_SIZE:    size_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dfvo_front u_front (
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .ordering_mode (mode_r),
    .order_size    (size_r),
    .q_full        (q_full),
    .push          (push),
    .job           (push_job)
  );

  dfvo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  dfvo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> src/dfvo_checker.sv
// Port-level checks for the diagonal frequency value order block.
// Bound to the top level; uses dfvo_pkg for the value range.
`default_nettype none
module dfvo_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Emitted values lie in 1..MAX_ORDER
  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[4:0] != 5'd0) &&
                   (out_tdata[4:0] <= 5'(dfvo_pkg::MAX_ORDER)))
    else $error("value out of range");

  // At most four neighbors can match
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:5] <= 3'(dfvo_pkg::NB_NUM))
    else $error("neighbor count out of range");

  // No result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind diagonal_frequency_value_order dfvo_checker u_dfvo_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for diagonal_frequency_value_order: predicts the ordered
// candidate stream for each input transfer and compares every output transfer.
// Depends on dfvo_pkg and the diagonal_frequency_value_order RTL.
`default_nettype none
module testbench;

  localparam int QUIET_LIMIT = 4000;  // cycles with no transfer before giving up
  localparam int SETTLE      = 24;    // idle cycles after the last result of a phase
  localparam int NPH         = 10;

  typedef struct packed {
    logic [4:0]  down_right;
    logic [4:0]  down_left;
    logic [4:0]  up_right;
    logic [4:0]  up_left;
    logic [16:0] mask;
    logic        use_mask;
  } cand_item_t;

  typedef struct packed {
    logic [4:0] value;
    logic [2:0] count;
    logic       last;
  } order_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = dfvo_pkg::CFG_ORDERING_MODE;
  logic [dfvo_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Shadow copy of the configuration registers
  logic       mode_q = dfvo_pkg::MODE_ASCENDING;
  logic [4:0] size_q = 5'd16;

  cand_item_t    pending_items[$];
  order_result_t expected_order[$];
  cand_item_t    drive_item;
  int items_queued = 0;
  int items_taken = 0;
  int in_gap = 0;
  int out_gap = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;

  // Setting per phase; the size-zero phase gives empty candidate sets, the oversize one saturates
  logic phase_mode[NPH] = '{dfvo_pkg::MODE_BY_FREQUENCY, dfvo_pkg::MODE_ASCENDING,
                            dfvo_pkg::MODE_BY_FREQUENCY, dfvo_pkg::MODE_BY_FREQUENCY,
                            dfvo_pkg::MODE_ASCENDING,    dfvo_pkg::MODE_BY_FREQUENCY,
                            dfvo_pkg::MODE_ASCENDING,    dfvo_pkg::MODE_BY_FREQUENCY,
                            dfvo_pkg::MODE_ASCENDING,    dfvo_pkg::MODE_BY_FREQUENCY};
  int phase_size[NPH]  = '{16, 1, 1, 5, 9, 12, 0, 31, 16, 16};
  int phase_items[NPH] = '{22, 18, 18, 22, 22, 22, 6, 22, 22, 22};

  diagonal_frequency_value_order uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Expected ordering of the candidates of one item under the current setting
  task automatic queue_expected_values(input cand_item_t it);
    int   sz;
    int   n;
    int   v;
    int   c;
    int   k;
    logic allowed[dfvo_pkg::MAX_ORDER+1];
    int   cnt[dfvo_pkg::MAX_ORDER+1];
    int   vals[dfvo_pkg::MAX_ORDER];
    int   cnts[dfvo_pkg::MAX_ORDER];
    logic [4:0] nb[4];
    order_result_t r;
    nb[0] = it.down_right;
    nb[1] = it.down_left;
    nb[2] = it.up_right;
    nb[3] = it.up_left;
    sz = (int'(size_q) > dfvo_pkg::MAX_ORDER) ? dfvo_pkg::MAX_ORDER : int'(size_q);
    n = 0;
    for (v = 0; v <= dfvo_pkg::MAX_ORDER; v++) begin
      allowed[v] = 1'b0;
      cnt[v] = 0;
    end
    for (v = 1; v <= sz; v++) begin
      allowed[v] = it.use_mask ? it.mask[v] : 1'b1;
      for (k = 0; k < 4; k++)
        if (int'(nb[k]) == v) cnt[v]++;
    end
    if (mode_q == dfvo_pkg::MODE_BY_FREQUENCY) begin
      // most frequent first, larger value wins a tie
      for (c = 4; c >= 0; c--)
        for (v = sz; v >= 1; v--)
          if (allowed[v] && cnt[v] == c) begin
            vals[n] = v;
            cnts[n] = c;
            n++;
          end
    end else begin
      for (v = 1; v <= sz; v++)
        if (allowed[v]) begin
          vals[n] = v;
          cnts[n] = 0;
          n++;
        end
    end
    for (k = 0; k < n; k++) begin
      r.value = vals[k][4:0];
      r.count = cnts[k][2:0];
      r.last  = (k == n - 1);
      expected_order = {expected_order, r};
    end
  endtask

  function automatic cand_item_t mk_item(input logic [4:0] dr, input logic [4:0] dl,
                                         input logic [4:0] ur, input logic [4:0] ul,
                                         input logic [16:0] mask, input logic use_mask);
    cand_item_t it;
    it.down_right = dr;
    it.down_left  = dl;
    it.up_right   = ur;
    it.up_left    = ul;
    it.mask       = mask;
    it.use_mask   = use_mask;
    return it;
  endfunction

  // Mostly neighbours inside the grid with a favored value, some pure noise
  function automatic cand_item_t random_item(input int sz);
    cand_item_t it;
    logic [4:0] nb[4];
    int lim;
    int hot;
    int pick;
    int k;
    lim = (sz < 1) ? 1 : ((sz > dfvo_pkg::MAX_ORDER) ? dfvo_pkg::MAX_ORDER : sz);
    hot = $urandom_range(1, lim);
    pick = $urandom_range(0, 9);
    for (k = 0; k < 4; k++) begin
      if (pick == 0) nb[k] = 5'($urandom);
      else begin
        case ($urandom_range(0, 3))
          0:       nb[k] = 5'd0;
          3:       nb[k] = 5'($urandom_range(1, lim));
          default: nb[k] = 5'(hot);
        endcase
      end
    end
    it.down_right = nb[0];
    it.down_left  = nb[1];
    it.up_right   = nb[2];
    it.up_left    = nb[3];
    case ($urandom_range(0, 5))
      0:       it.mask = '0;
      1:       it.mask = '1;
      default: it.mask = 17'($urandom);
    endcase
    it.use_mask = ($urandom_range(0, 3) != 0);
    return it;
  endfunction

  task automatic write_reg(input logic idx, input logic [dfvo_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == dfvo_pkg::CFG_ORDERING_MODE) mode_q = val[0];
    else size_q = val;
  endtask

  task automatic apply_setting(input logic mode, input int sz);
    write_reg(dfvo_pkg::CFG_ORDERING_MODE, {{(dfvo_pkg::CFG_W-1){1'b0}}, mode});
    write_reg(dfvo_pkg::CFG_ORDER_SIZE, dfvo_pkg::CFG_W'(sz));
  endtask

  task automatic enqueue(input cand_item_t it);
    pending_items = {pending_items, it};
    items_queued++;
  endtask

  // Wait until every item is taken and every result has come, then let the block settle
  task automatic drain_results();
    while (items_taken != items_queued || expected_order.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Input driver: presents queued items, with random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        queue_expected_values(drive_item);
        items_taken++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the item until it is taken
      end else if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() != 0 && (calm || $urandom_range(0, 3) != 0)) begin
        drive_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {3'b000, drive_item.mask, drive_item.up_left, drive_item.up_right,
                      drive_item.down_left, drive_item.down_right};
        in_tuser  <= drive_item.use_mask;
      end else if (pending_items.size() != 0) begin
        in_gap = $urandom_range(0, 9);
        in_tvalid <= 1'b0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each transfer against the oldest expectation
  always @(posedge clk) begin
    order_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_order.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: value=%0d count=%0d last=%0b",
                     out_tdata[4:0], out_tdata[7:5], out_tlast);
          mismatches++;
        end else begin
          want = expected_order.pop_front();
          if (out_tdata[4:0] !== want.value || out_tdata[7:5] !== want.count ||
              out_tlast !== want.last) begin
            if (mismatches < 10)
              $display("mismatch: expected value=%0d count=%0d last=%0b, got %0d %0d %0b",
                       want.value, want.count, want.last,
                       out_tdata[4:0], out_tdata[7:5], out_tlast);
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Count cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("** diagonal_frequency_value_order: FAILED **");
    $finish;
  end

  // Stimulus sequence
  initial begin
    int p;
    int i;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: sequential, size 16
    enqueue(mk_item(5'd0, 5'd0, 5'd0, 5'd0, 17'h00000, 1'b0));   // every value
    enqueue(mk_item(5'd16, 5'd16, 5'd1, 5'd2, 17'h1ffff, 1'b1));
    enqueue(mk_item(5'd3, 5'd4, 5'd5, 5'd6, 17'h00000, 1'b1));   // empty set
    enqueue(mk_item(5'd1, 5'd1, 5'd1, 5'd1, 17'h00001, 1'b1));   // bit 0 only
    enqueue(mk_item(5'd31, 5'd31, 5'd31, 5'd31, 17'h1ffff, 1'b1));
    drain_results();

    // Frequency order, full grid
    apply_setting(dfvo_pkg::MODE_BY_FREQUENCY, 16);
    enqueue(mk_item(5'd16, 5'd16, 5'd16, 5'd16, 17'h00000, 1'b0)); // count of four
    enqueue(mk_item(5'd31, 5'd17, 5'd0, 5'd5, 17'h0aaaa, 1'b1));  // out-of-range neighbours
    enqueue(mk_item(5'd3, 5'd3, 5'd7, 5'd7, 17'h1ffff, 1'b1));    // tie on count
    enqueue(mk_item(5'd2, 5'd9, 5'd2, 5'd9, 17'h00000, 1'b0));    // mask ignored
    enqueue(mk_item(5'd31, 5'd31, 5'd31, 5'd31, 17'h1ffff, 1'b1));
    enqueue(mk_item(5'd1, 5'd1, 5'd1, 5'd2, 17'h00006, 1'b1));
    drain_results();

    // Zero size: nothing to emit
    apply_setting(dfvo_pkg::MODE_ASCENDING, 0);
    enqueue(mk_item(5'd1, 5'd2, 5'd3, 5'd4, 17'h1ffff, 1'b0));
    enqueue(mk_item(5'd1, 5'd2, 5'd3, 5'd4, 17'h1ffff, 1'b1));
    drain_results();

    // Oversize saturates to the largest order
    apply_setting(dfvo_pkg::MODE_BY_FREQUENCY, 31);
    enqueue(mk_item(5'd16, 5'd16, 5'd1, 5'd2, 17'h00000, 1'b0));
    enqueue(mk_item(5'd17, 5'd18, 5'd30, 5'd16, 17'h1fffe, 1'b1));
    drain_results();

    // Mask bits above the size are ignored
    apply_setting(dfvo_pkg::MODE_ASCENDING, 1);
    enqueue(mk_item(5'd1, 5'd2, 5'd1, 5'd0, 17'h1fffc, 1'b1));
    enqueue(mk_item(5'd1, 5'd0, 5'd0, 5'd0, 17'h00002, 1'b1));
    drain_results();

    // Random phases, last one without idling
    for (p = 0; p < NPH; p++) begin
      if (p == NPH - 1) calm = 1'b1;
      apply_setting(phase_mode[p], phase_size[p]);
      for (i = 0; i < phase_items[p]; i++) enqueue(random_item(phase_size[p]));
      drain_results();
    end

    if (mismatches == 0 && expected_order.size() == 0) begin
      $display("** diagonal_frequency_value_order: PASSED **");
    end else begin
      $display("** diagonal_frequency_value_order: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
